// ----- rtl/camellia_block_encrypt_assert.svh -----
// Assertion macros shared by the camellia RTL files.
// Depends on nothing; included inside module bodies.
`ifndef CAMELLIA_BLOCK_ENCRYPT_ASSERT_SVH
`define CAMELLIA_BLOCK_ENCRYPT_ASSERT_SVH
`define CAM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CAM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`endif

// ----- rtl/cam_pkg.sv -----
// Camellia constants, types, s-box and F/FL functions.
// Used by every camellia RTL module.
`default_nettype none
package cam_pkg;
  localparam int SlotCount = 34;
  localparam int SlotKl = 24;
  localparam int SlotKw = 30;
  localparam int RoundMax = 24;
  localparam int Stages = RoundMax + 5;
  localparam int FifoDepth = 4;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_ENC = 1'b1;

  typedef logic [63:0] word_t;

  typedef struct packed {
    word_t hi;
    word_t lo;
  } blk_t;

  typedef struct packed {
    logic  full;
    logic  empty;
  } qstat_t;

  localparam logic [7:0] SBOX [256] = '{
    112,130, 44,236,179, 39,192,229,228,133, 87, 53,234, 12,174, 65,
     35,239,107,147, 69, 25,165, 33,237, 14, 79, 78, 29,101,146,189,
    134,184,175,143,124,235, 31,206, 62, 48,220, 95, 94,197, 11, 26,
    166,225, 57,202,213, 71, 93, 61,217,  1, 90,214, 81, 86,108, 77,
    139, 13,154,102,251,204,176, 45,116, 18, 43, 32,240,177,132,153,
    223, 76,203,194, 52,126,118,  5,109,183,169, 49,209, 23,  4,215,
     20, 88, 58, 97,222, 27, 17, 28, 50, 15,156, 22, 83, 24,242, 34,
    254, 68,207,178,195,181,122,145, 36,  8,232,168, 96,252,105, 80,
    170,208,160,125,161,137, 98,151, 84, 91, 30,149,224,255,100,210,
     16,196,  0, 72,163,247,117,219,138,  3,230,218,  9, 63,221,148,
    135, 92,131,  2,205, 74,144, 51,115,103,246,243,157,127,191,226,
     82,155,216, 38,200, 55,198, 59,129,150,111, 75, 19,190, 99, 46,
    233,121,167,140,159,110,188,142, 41,245,249,182, 47,253,180, 89,
    120,152,  6,106,231, 70,113,186,212, 37,171, 66,136,162,141,250,
    114,  7,185, 85,248,238,172, 10, 54, 73, 42,104, 60, 56,241,164,
     64, 40,211,123,187,201, 67,193, 21,227,173,244,119,199,128,158
  };

  function automatic logic [7:0] s1(input logic [7:0] x);
    s1 = SBOX[x];
  endfunction
  function automatic logic [7:0] s2(input logic [7:0] x);
    logic [7:0] v;
    v = SBOX[x];
    s2 = {v[6:0], v[7]};
  endfunction
  function automatic logic [7:0] s3(input logic [7:0] x);
    logic [7:0] v;
    v = SBOX[x];
    s3 = {v[0], v[7:1]};
  endfunction
  function automatic logic [7:0] s4(input logic [7:0] x);
    s4 = SBOX[{x[6:0], x[7]}];
  endfunction

  function automatic word_t f_fn(input word_t d, input word_t k);
    word_t x;
    logic [7:0] t1, t2, t3, t4, t5, t6, t7, t8;
    x = d ^ k;
    t1 = s1(x[63:56]); t2 = s2(x[55:48]); t3 = s3(x[47:40]); t4 = s4(x[39:32]);
    t5 = s2(x[31:24]); t6 = s3(x[23:16]); t7 = s4(x[15:8]);  t8 = s1(x[7:0]);
    f_fn = {t1 ^ t3 ^ t4 ^ t6 ^ t7 ^ t8, t1 ^ t2 ^ t4 ^ t5 ^ t7 ^ t8,
            t1 ^ t2 ^ t3 ^ t5 ^ t6 ^ t8, t2 ^ t3 ^ t4 ^ t5 ^ t6 ^ t7,
            t1 ^ t2 ^ t6 ^ t7 ^ t8,      t2 ^ t3 ^ t5 ^ t7 ^ t8,
            t3 ^ t4 ^ t5 ^ t6 ^ t8,      t1 ^ t4 ^ t5 ^ t6 ^ t7};
  endfunction

  function automatic logic [31:0] rotl1(input logic [31:0] v);
    rotl1 = {v[30:0], v[31]};
  endfunction

  function automatic word_t fl_fwd(input word_t d, input word_t k);
    logic [31:0] x1, x2;
    x1 = d[63:32];
    x2 = d[31:0] ^ rotl1(d[63:32] & k[63:32]);
    x1 = x1 ^ (x2 | k[31:0]);
    fl_fwd = {x1, x2};
  endfunction

  function automatic word_t fl_inv(input word_t d, input word_t k);
    logic [31:0] y1, y2;
    y1 = d[63:32] ^ (d[31:0] | k[31:0]);
    y2 = d[31:0] ^ rotl1(y1 & k[63:32]);
    fl_inv = {y1, y2};
  endfunction
endpackage
`default_nettype wire

// ----- rtl/cam_front.sv -----
// Front end: accepts items, writes the subkey store, queues encrypt blocks.
// Depends on cam_pkg.
`default_nettype none
module cam_front #(
  parameter int QDEPTH = cam_pkg::FifoDepth
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic           op,
  input  wire logic [5:0]     idx,
  input  wire cam_pkg::word_t val,
  input  wire cam_pkg::blk_t  plain,
  input  wire logic           back_busy,
  output logic                key_we,
  output logic [5:0]          key_idx,
  output cam_pkg::word_t      key_val,
  output logic                q_valid,
  input  wire logic           q_ready,
  output cam_pkg::blk_t       q_data,
  output cam_pkg::qstat_t     q_stat
);
  import cam_pkg::*;
  localparam int AW = $clog2(QDEPTH);
  blk_t          mem_r [QDEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          push, pop;

  assign q_stat.full  = (cnt_r == (AW+1)'(QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  // hold a load until every queued and running block is done
  assign in_ready = !q_stat.full &&
                    ((op == OP_ENC) || (q_stat.empty && !back_busy));
  assign push = in_valid && in_ready && (op == OP_ENC);
  assign pop  = q_valid && q_ready;
  assign q_valid = !q_stat.empty;
  assign q_data  = mem_r[rp_r];
  assign key_we  = in_valid && in_ready && (op == OP_LOAD) && (idx < 6'(SlotCount));
  assign key_idx = idx;
  assign key_val = val;
  assign cnt_nxt = cnt_r + (AW+1)'(push) - (AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= plain;
    end
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (pop) rp_r <= (rp_r == AW'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  `include "camellia_block_encrypt_assert.svh"
  `CAM_ASSERT(a_cnt_range, (cnt_r <= (AW+1)'(QDEPTH)), "queue count overflow")
  `CAM_ASSERT_NEXT(a_push_cnt, (push && !pop), (cnt_r == $past(cnt_r) + 1'b1), "push lost")
  `CAM_ASSERT(a_excl, !(push && key_we), "load and encrypt at once")
endmodule
`default_nettype wire

// ----- rtl/cam_back.sv -----
// Back end: subkey store and 29-stage encryption pipeline, stalled by the output.
// Depends on cam_pkg.
`default_nettype none
module cam_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           long_mode,
  input  wire logic           key_we,
  input  wire logic [5:0]     key_idx,
  input  wire cam_pkg::word_t key_val,
  input  wire logic           q_valid,
  output logic                q_ready,
  input  wire cam_pkg::blk_t  q_data,
  output logic                o_valid,
  input  wire logic           o_ready,
  output cam_pkg::blk_t       o_data,
  output logic                busy
);
  import cam_pkg::*;
  localparam int STAGES = Stages;
  word_t key_r [SlotCount];
  logic  vld_r [1:STAGES];
  logic  lm_r  [1:STAGES];
  blk_t  dat_r [1:STAGES];
  logic  adv;

  always_ff @(posedge clk) begin
    if (key_we) key_r[key_idx] <= key_val;
  end

  // pipeline advances when its last stage is free or being drained
  assign adv = !vld_r[STAGES] || o_ready;
  assign q_ready = adv;

  always_comb begin
    busy = 1'b0;
    for (int i = 1; i <= STAGES; i++) busy = busy | vld_r[i];
  end

  genvar g;
  generate
    for (g = 0; g < STAGES; g++) begin : g_st
      blk_t d_in, d_out;
      logic v_in, m_in;
      if (g == 0) begin : g_src
        assign d_in = q_data;
        assign v_in = q_valid;
        assign m_in = long_mode;
      end else begin : g_mid
        assign d_in = dat_r[g];
        assign v_in = vld_r[g];
        assign m_in = lm_r[g];
      end
      if (g == 0) begin : g_pre
        always_comb begin
          d_out.hi = d_in.hi ^ key_r[SlotKw];
          d_out.lo = d_in.lo ^ key_r[SlotKw+1];
        end
      end else if (g == STAGES-1) begin : g_post
        always_comb begin
          d_out.hi = d_in.lo ^ key_r[SlotKw+2];
          d_out.lo = d_in.hi ^ key_r[SlotKw+3];
        end
      end else if (g % 7 == 0) begin : g_fl
        localparam int Fl = g / 7 - 1;
        always_comb begin
          d_out = d_in;
          if (Fl < 2 || m_in) begin
            d_out.hi = fl_fwd(d_in.hi, key_r[SlotKl + 2*Fl]);
            d_out.lo = fl_inv(d_in.lo, key_r[SlotKl + 2*Fl + 1]);
          end
        end
      end else begin : g_rnd
        localparam int Rk = (g - 1) - (g - 1) / 7;
        always_comb begin
          d_out = d_in;
          if (Rk < 18 || m_in) begin
            if (Rk % 2 == 0)
              d_out.lo = d_in.lo ^ f_fn(d_in.hi, key_r[Rk]);
            else
              d_out.hi = d_in.hi ^ f_fn(d_in.lo, key_r[Rk]);
          end
        end
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          dat_r[g+1] <= d_out;
          lm_r[g+1] <= m_in;
        end
        if (!rst_n) vld_r[g+1] <= 1'b0;
        else if (adv) vld_r[g+1] <= v_in;
      end
    end
  endgenerate

  assign o_valid = vld_r[STAGES];
  assign o_data  = dat_r[STAGES];

  `include "camellia_block_encrypt_assert.svh"
  `CAM_ASSERT(a_key_idle, !(key_we && (q_valid || busy)), "subkey written under load")
  `CAM_ASSERT_NEXT(a_hold, (o_valid && !o_ready), (o_valid && $stable(o_data)), "result dropped")
  `CAM_ASSERT(a_stall, (!(o_valid && !o_ready) || !q_ready), "pipe moves under stall")
endmodule
`default_nettype wire

// ----- rtl/camellia_block_encrypt.sv -----
// Top level of the Camellia encryption block: config register, front, back.
// Depends on cam_pkg, cam_front, cam_back.
//  channel | dir | payload
//  in_     | in  | op, subkey_index, subkey_value, plain_high, plain_low
//  out_    | out | cipher_high, cipher_low
//  cfg_    | in  | long_key_mode
// One encrypt block per cycle while out_tready does not stall the output.
// 29 stages: whitening, 24 rounds, three FL layers, output whitening.
// Short-key blocks pass the last FL layer and six rounds through unchanged.
// A load transfer waits until the queue and the pipeline are empty.
// Reset clears queue, pipeline valids and mode; the subkey store is unset.
// Output stall freezes the pipeline; the queue then fills and drops in_tready.
`default_nettype none
module camellia_block_encrypt #(
  parameter int QDEPTH = cam_pkg::FifoDepth
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [0] op, [6:1] subkey_index, [70:7] subkey_value,
  // [134:71] plain_high, [198:135] plain_low, [199] zero
  input  wire logic [199:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [63:0] cipher_high, [127:64] cipher_low
  output logic [127:0]      out_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic         cfg_data
);
  import cam_pkg::*;
  logic           mode_r;
  logic           key_we, q_valid, q_ready, back_busy;
  logic [5:0]     key_idx;
  word_t          key_val;
  blk_t           q_data, o_data, plain;
  qstat_t         q_stat;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) mode_r <= 1'b0;
    else if (cfg_valid) mode_r <= cfg_data;
  end

  assign plain.hi = in_tdata[134:71];
  assign plain.lo = in_tdata[198:135];

  cam_front #(.QDEPTH(QDEPTH)) u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .op(in_tdata[0]), .idx(in_tdata[6:1]), .val(in_tdata[70:7]), .plain,
    .back_busy, .key_we, .key_idx, .key_val, .q_valid, .q_ready, .q_data, .q_stat
  );

  cam_back u_back (
    .clk, .rst_n, .long_mode(mode_r), .key_we, .key_idx, .key_val,
    .q_valid, .q_ready, .q_data, .o_valid(out_tvalid), .o_ready(out_tready),
    .o_data, .busy(back_busy)
  );

  assign out_tdata = {o_data.lo, o_data.hi};

  `include "camellia_block_encrypt_assert.svh"
  `CAM_ASSERT(a_ready, (!in_tready || !q_stat.full), "ready while full")
  `CAM_ASSERT_NEXT(a_empty, (q_stat.empty && !(in_tvalid && in_tready)), !q_valid, "ghost item")
  `CAM_ASSERT(a_cfg, (cfg_ready), "cfg stalled")
endmodule
`default_nettype wire

// ----- tb/camellia_block_encrypt_tb.sv -----
// Self-checking testbench for camellia_block_encrypt: loads subkeys, encrypts blocks
// in both key modes with random gaps and stalls. Depends on cam_pkg and the RTL top.
`default_nettype none
module camellia_block_encrypt_tb;
  import cam_pkg::*;

  localparam int GapMax = 14;
  localparam int Watchdog = 5000;
  localparam int DrainCycles = 40;
  localparam int RandItems = 1080;

  typedef struct {
    logic        op;
    logic [5:0]  idx;
    logic [63:0] val;
    logic [63:0] ph;
    logic [63:0] pl;
    logic        known;
    logic [63:0] ch;
    logic [63:0] cl;
  } row_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready;
  logic [199:0] in_tdata;
  logic out_tvalid, out_tready;
  logic [127:0] out_tdata;
  logic cfg_valid, cfg_ready, cfg_data;

  logic [63:0] key_slots [SlotCount];
  logic        mode_long;
  logic [127:0] cipher_q [$];
  int errors, idle_cycles, hold_off, rx_wait, rx_count;
  bit long_hold_done;

  camellia_block_encrypt uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] sb(input logic [7:0] x);
    logic [7:0] tbl [256];
    tbl = '{
      112,130, 44,236,179, 39,192,229,228,133, 87, 53,234, 12,174, 65,
       35,239,107,147, 69, 25,165, 33,237, 14, 79, 78, 29,101,146,189,
      134,184,175,143,124,235, 31,206, 62, 48,220, 95, 94,197, 11, 26,
      166,225, 57,202,213, 71, 93, 61,217,  1, 90,214, 81, 86,108, 77,
      139, 13,154,102,251,204,176, 45,116, 18, 43, 32,240,177,132,153,
      223, 76,203,194, 52,126,118,  5,109,183,169, 49,209, 23,  4,215,
       20, 88, 58, 97,222, 27, 17, 28, 50, 15,156, 22, 83, 24,242, 34,
      254, 68,207,178,195,181,122,145, 36,  8,232,168, 96,252,105, 80,
      170,208,160,125,161,137, 98,151, 84, 91, 30,149,224,255,100,210,
       16,196,  0, 72,163,247,117,219,138,  3,230,218,  9, 63,221,148,
      135, 92,131,  2,205, 74,144, 51,115,103,246,243,157,127,191,226,
       82,155,216, 38,200, 55,198, 59,129,150,111, 75, 19,190, 99, 46,
      233,121,167,140,159,110,188,142, 41,245,249,182, 47,253,180, 89,
      120,152,  6,106,231, 70,113,186,212, 37,171, 66,136,162,141,250,
      114,  7,185, 85,248,238,172, 10, 54, 73, 42,104, 60, 56,241,164,
       64, 40,211,123,187,201, 67,193, 21,227,173,244,119,199,128,158};
    return tbl[x];
  endfunction

  function automatic logic [63:0] feistel(input logic [63:0] d, input logic [63:0] k);
    logic [63:0] x;
    logic [7:0] a [8];
    logic [7:0] v;
    x = d ^ k;
    a[0] = sb(x[63:56]);
    v = sb(x[55:48]); a[1] = {v[6:0], v[7]};
    v = sb(x[47:40]); a[2] = {v[0], v[7:1]};
    a[3] = sb({x[38:32], x[39]});
    v = sb(x[31:24]); a[4] = {v[6:0], v[7]};
    v = sb(x[23:16]); a[5] = {v[0], v[7:1]};
    a[6] = sb({x[14:8], x[15]});
    a[7] = sb(x[7:0]);
    return {a[0]^a[2]^a[3]^a[5]^a[6]^a[7], a[0]^a[1]^a[3]^a[4]^a[6]^a[7],
            a[0]^a[1]^a[2]^a[4]^a[5]^a[7], a[1]^a[2]^a[3]^a[4]^a[5]^a[6],
            a[0]^a[1]^a[5]^a[6]^a[7],      a[1]^a[2]^a[4]^a[6]^a[7],
            a[2]^a[3]^a[4]^a[5]^a[7],      a[0]^a[3]^a[4]^a[5]^a[6]};
  endfunction

  function automatic logic [31:0] rot1(input logic [31:0] v);
    return {v[30:0], v[31]};
  endfunction

  function automatic logic [127:0] predict_cipher(input logic [63:0] ph,
                                                  input logic [63:0] pl);
    logic [63:0] l, r, k;
    logic [31:0] h1, h2;
    int nblk;
    l = ph ^ key_slots[SlotKw];
    r = pl ^ key_slots[SlotKw + 1];
    nblk = mode_long ? 4 : 3;
    for (int b = 0; b < nblk; b++) begin
      if (b > 0) begin
        k = key_slots[SlotKl + 2 * (b - 1)];
        h1 = l[63:32];
        h2 = l[31:0] ^ rot1(h1 & k[63:32]);
        h1 = h1 ^ (h2 | k[31:0]);
        l = {h1, h2};
        k = key_slots[SlotKl + 2 * (b - 1) + 1];
        h1 = r[63:32] ^ (r[31:0] | k[31:0]);
        h2 = r[31:0] ^ rot1(h1 & k[63:32]);
        r = {h1, h2};
      end
      for (int j = 0; j < 6; j += 2) begin
        r = r ^ feistel(l, key_slots[6 * b + j]);
        l = l ^ feistel(r, key_slots[6 * b + j + 1]);
      end
    end
    return {l ^ key_slots[SlotKw + 3], r ^ key_slots[SlotKw + 2]};
  endfunction

  task automatic report_mismatch(input string what, input logic [127:0] got,
                                 input logic [127:0] want);
    errors++;
    $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  // leave in_tvalid high after a transfer; the next call or the caller drops it
  task automatic send_item(input row_t r);
    int gap;
    gap = $urandom_range(0, GapMax);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, r.pl, r.ph, r.val, r.idx, r.op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (r.op == OP_LOAD) begin
      if (r.idx < SlotCount) key_slots[r.idx] = r.val;
    end else begin
      cipher_q.insert(cipher_q.size(),
                      r.known ? {r.cl, r.ch} : predict_cipher(r.ph, r.pl));
    end
  endtask

  task automatic write_mode(input logic m);
    in_tvalid <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    mode_long = m;
  endtask

  function automatic row_t load_row(input logic [5:0] i, input logic [63:0] v);
    row_t r;
    r = '{OP_LOAD, i, v, 64'($urandom), 64'($urandom), 1'b0, 64'd0, 64'd0};
    return r;
  endfunction

  function automatic row_t enc_row(input logic [63:0] ph, input logic [63:0] pl);
    row_t r;
    r = '{OP_ENC, 6'($urandom), {$urandom, $urandom}, ph, pl, 1'b0, 64'd0, 64'd0};
    return r;
  endfunction

  task automatic load_all(input int pattern);
    for (int i = 0; i < SlotCount; i++)
      case (pattern)
        0: send_item(load_row(6'(i), 64'd0));
        1: send_item(load_row(6'(i), '1));
        default: send_item(load_row(6'(i), {$urandom, $urandom}));
      endcase
  endtask

  // receiver: per-item waits, one long hold-off after 40 items and rare random hold-offs
  always @(posedge clk) begin : p_rx
    int w;
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_off <= 0;
      rx_wait <= 0;
      rx_count <= 0;
      long_hold_done <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        rx_count <= rx_count + 1;
        if (cipher_q.size() == 0) report_mismatch("unexpected", out_tdata, 128'd0);
        else begin
          if (out_tdata[63:0] !== cipher_q[0][63:0])
            report_mismatch("cipher_high", out_tdata, cipher_q[0]);
          if (out_tdata[127:64] !== cipher_q[0][127:64])
            report_mismatch("cipher_low", out_tdata, cipher_q[0]);
          void'(cipher_q.pop_front());
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_tready <= 1'b0;
      end else if ((!long_hold_done && rx_count == 40) ||
                   $urandom_range(0, 999) == 0) begin
        long_hold_done <= 1'b1;
        hold_off <= 200;
        out_tready <= 1'b0;
      end else if (out_tvalid && out_tready) begin
        w = $urandom_range(0, GapMax);
        rx_wait <= w;
        out_tready <= (w == 0);
      end else if (rx_wait > 0) begin
        rx_wait <= rx_wait - 1;
        out_tready <= (rx_wait == 1);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= Watchdog) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    row_t dir [$];
    rst_n = 0; in_tvalid = 0; in_tdata = '0; cfg_valid = 0; cfg_data = 0;
    errors = 0; mode_long = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all-zero keys, short key: directed plaintexts with subkey loads between, some to out-of-range slots
    load_all(0);
    dir.insert(dir.size(), enc_row(64'd0, 64'd0));
    dir.insert(dir.size(), enc_row('1, '1));
    dir.insert(dir.size(), enc_row(64'd0, '1));
    dir.insert(dir.size(), load_row(6'd34, '1));
    dir.insert(dir.size(), load_row(6'd63, '1));
    dir.insert(dir.size(), enc_row(64'h0123456789abcdef, 64'hfedcba9876543210));
    dir.insert(dir.size(), load_row(6'd33, '1));
    dir.insert(dir.size(), load_row(6'd30, 64'h8000000000000001));
    dir.insert(dir.size(), enc_row('1, 64'd0));
    dir.insert(dir.size(), load_row(6'd0, '1));
    dir.insert(dir.size(), load_row(6'd24, 64'hffffffff00000000));
    dir.insert(dir.size(), load_row(6'd25, 64'h00000000ffffffff));
    dir.insert(dir.size(), enc_row(64'h0123456789abcdef, 64'hfedcba9876543210));
    foreach (dir[i]) send_item(dir[i]);

    write_mode(1'b1);
    load_all(1);
    send_item(enc_row(64'd0, 64'd0));
    send_item(enc_row('1, '1));
    write_mode(1'b0);
    send_item(enc_row('1, '1));

    for (int phase = 0; phase < 6; phase++) begin
      write_mode(phase[0]);
      if (phase > 1) load_all(2);
      for (int i = 0; i < RandItems / 6; i++) begin
        case ($urandom_range(0, 9))
          0: send_item(load_row(6'($urandom_range(0, 63)), {$urandom, $urandom}));
          1: send_item(load_row(6'($urandom_range(0, 33)), {$urandom, $urandom}));
          default: send_item(enc_row({$urandom, $urandom}, {$urandom, $urandom}));
        endcase
      end
    end
    in_tvalid <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire
